[rtl/dat_pkg.sv]
// Shared types, codes and constants of the dual-antenna tag arbiter.
package dat_pkg;

    localparam int TAG_HI_W = 32;
    localparam int TAG_LO_W = 64;
    localparam int RSSI_W   = 12;
    localparam int TIME_W   = 32;
    localparam int SM_W     = 20;
    localparam int SLOT_W   = 5;
    localparam int MARGIN_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int EVN_W    = 6;
    localparam logic [EVN_W-1:0] MAX_EVENTS = 6'd32;
    localparam logic [MARGIN_W-1:0] MARGIN_SAT = 12'd2559;

    localparam logic [1:0] ANT_NONE = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_SWEEP = 1'b1;
    localparam logic EV_COMMIT  = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd4;

    typedef struct packed {
        logic                op;
        logic                antenna;
        logic [TAG_HI_W-1:0] tag_id_high;
        logic [TAG_LO_W-1:0] tag_id_low;
        logic [RSSI_W-1:0]   rssi_tenths;
        logic [TIME_W-1:0]   time_ms;
    } in_t;

    typedef struct packed {
        logic                event_res;
        logic [SLOT_W-1:0]   slot;
        logic                owner_antenna;
        logic [TAG_HI_W-1:0] tag_high;
        logic [TAG_LO_W-1:0] tag_low;
        logic [MARGIN_W-1:0] margin_tenths;
        logic                sole_reader;
        logic [TIME_W-1:0]   decide_ms;
        logic                last;
    } out_t;

    typedef struct packed {
        logic [TAG_HI_W-1:0]         tag_high;
        logic [TAG_LO_W-1:0]         tag_low;
        logic [1:0][RSSI_W-1:0]      rssi;
        logic [1:0][SM_W-1:0]        sm;
        logic [1:0]                  smv;
        logic [1:0]                  cand;
        logic [7:0]                  streak;
        logic [1:0]                  owner;
        logic [TIME_W-1:0]           start_ms;
        logic [TIME_W-1:0]           last_ms;
    } rec_t;

    typedef struct packed {
        logic in_load;
        logic sweep_init;
        logic idx_inc;
        logic mem_rd;
        logic cmp_step;
        logic set_hit;
        logic goto_free;
        logic read_wr;
        logic rec_load;
        logic mul_en;
        logic add_en;
        logic ant;
        logic dec_en;
        logic emit_step;
        logic flush_push;
        logic seen_clr;
    } cmd_t;

    typedef struct packed {
        logic used_cur;
        logic hit;
        logic idx_last;
        logic free_avail;
        logic ev_flag;
        logic pend_valid;
        logic out_free;
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_READ_WR,
        ST_SW_RD,
        ST_SW_LOAD,
        ST_SW_MUL0,
        ST_SW_ADD0,
        ST_SW_MUL1,
        ST_SW_ADD1,
        ST_SW_DEC,
        ST_SW_EMIT,
        ST_SW_FLUSH
    } state_t;

endpackage

[rtl/dat_ctrl.sv]
// Controller state machine sequencing tag lookup and the sweep walk.
module dat_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_op,
    output logic          s_ready,
    input  dat_pkg::stat_t stat,
    output dat_pkg::cmd_t  cmd
);

    dat_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dat_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dat_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == dat_pkg::OP_SWEEP) ? dat_pkg::ST_SW_RD
                                                             : dat_pkg::ST_FIND_RD;
                end
            end
            dat_pkg::ST_FIND_RD: state_next = dat_pkg::ST_FIND_CMP;
            dat_pkg::ST_FIND_CMP: begin
                if (stat.hit) begin
                    state_next = dat_pkg::ST_READ_WR;
                end else if (stat.idx_last) begin
                    state_next = stat.free_avail ? dat_pkg::ST_READ_WR : dat_pkg::ST_IDLE;
                end else begin
                    state_next = dat_pkg::ST_FIND_RD;
                end
            end
            dat_pkg::ST_READ_WR: state_next = dat_pkg::ST_IDLE;
            dat_pkg::ST_SW_RD: begin
                if (stat.used_cur) begin
                    state_next = dat_pkg::ST_SW_LOAD;
                end else if (stat.idx_last) begin
                    state_next = dat_pkg::ST_SW_FLUSH;
                end
            end
            dat_pkg::ST_SW_LOAD: state_next = dat_pkg::ST_SW_MUL0;
            dat_pkg::ST_SW_MUL0: state_next = dat_pkg::ST_SW_ADD0;
            dat_pkg::ST_SW_ADD0: state_next = dat_pkg::ST_SW_MUL1;
            dat_pkg::ST_SW_MUL1: state_next = dat_pkg::ST_SW_ADD1;
            dat_pkg::ST_SW_ADD1: state_next = dat_pkg::ST_SW_DEC;
            dat_pkg::ST_SW_DEC:  state_next = dat_pkg::ST_SW_EMIT;
            dat_pkg::ST_SW_EMIT: begin
                if (!(stat.ev_flag && stat.pend_valid && !stat.out_free)) begin
                    state_next = stat.idx_last ? dat_pkg::ST_SW_FLUSH : dat_pkg::ST_SW_RD;
                end
            end
            dat_pkg::ST_SW_FLUSH: begin
                if (!stat.pend_valid || stat.out_free) begin
                    state_next = dat_pkg::ST_IDLE;
                end
            end
            default: state_next = dat_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            dat_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_load    = 1'b1;
                    cmd.sweep_init = (s_op == dat_pkg::OP_SWEEP);
                end
            end
            dat_pkg::ST_FIND_RD: cmd.mem_rd = 1'b1;
            dat_pkg::ST_FIND_CMP: begin
                cmd.cmp_step = 1'b1;
                if (stat.hit) begin
                    cmd.set_hit = 1'b1;
                end else if (stat.idx_last) begin
                    cmd.goto_free = stat.free_avail;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            dat_pkg::ST_READ_WR: cmd.read_wr = 1'b1;
            dat_pkg::ST_SW_RD: begin
                if (stat.used_cur) begin
                    cmd.mem_rd = 1'b1;
                end else if (!stat.idx_last) begin
                    cmd.idx_inc = 1'b1;
                end
            end
            dat_pkg::ST_SW_LOAD: cmd.rec_load = 1'b1;
            dat_pkg::ST_SW_MUL0: cmd.mul_en = 1'b1;
            dat_pkg::ST_SW_ADD0: cmd.add_en = 1'b1;
            dat_pkg::ST_SW_MUL1: begin
                cmd.mul_en = 1'b1;
                cmd.ant    = 1'b1;
            end
            dat_pkg::ST_SW_ADD1: begin
                cmd.add_en = 1'b1;
                cmd.ant    = 1'b1;
            end
            dat_pkg::ST_SW_DEC: cmd.dec_en = 1'b1;
            dat_pkg::ST_SW_EMIT: begin
                if (!(stat.ev_flag && stat.pend_valid && !stat.out_free)) begin
                    cmd.emit_step = 1'b1;
                    cmd.idx_inc   = !stat.idx_last;
                end
            end
            dat_pkg::ST_SW_FLUSH: begin
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.flush_push = stat.pend_valid;
                    cmd.seen_clr   = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/dat_dpath.sv]
// Datapath: slot table memory, per-slot flags, smoothing, decision and event output.
module dat_dpath #(
    parameter int TRACK_COUNT = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dat_pkg::in_t                      s_data,
    input  logic                              cfg_valid,
    input  logic [dat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dat_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              m_ready,
    output logic                              m_valid,
    output dat_pkg::out_t                     m_data,
    input  dat_pkg::cmd_t                     cmd,
    output dat_pkg::stat_t                    stat
);

    localparam int IDX_W = $clog2(TRACK_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRACK_COUNT - 1);

    dat_pkg::rec_t mem [TRACK_COUNT];

    logic [15:0] rel_reg;
    logic [9:0]  mmargin_reg;
    logic [11:0] floor_reg;
    logic [7:0]  confirm_reg;
    logic [8:0]  alpha_reg;

    dat_pkg::in_t      in_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  free_reg;
    logic              free_found_reg;
    logic              alloc_reg;
    logic [TRACK_COUNT-1:0] used_reg, seen0_reg, seen1_reg;
    dat_pkg::rec_t     rdata_reg, rec_reg;
    logic signed [30:0] prod_reg;
    dat_pkg::out_t     ev_reg, pend_reg, m_data_reg;
    logic              ev_flag_reg, pend_valid_reg, m_valid_reg;
    logic [dat_pkg::EVN_W-1:0] n_reg;

    logic [1:0]        seen_cur;
    logic              out_free, out_push;
    logic [8:0]        alpha_sat;
    logic signed [19:0] raw_a, old_a, new_sm;
    logic signed [20:0] diff_a;
    logic signed [30:0] prod_c, step_c;
    logic signed [20:0] sum_c;
    dat_pkg::rec_t     wr_rec, dec_rec, sm_rec;
    dat_pkg::out_t     push_data;
    logic              rd_seen_a, rd_take;

    logic signed [19:0] d0, d1, lvl;
    logic signed [20:0] dd;
    logic [20:0]       margin;
    logic              sole, cand, pass, commit, release_now, dec_ev;
    logic [7:0]        streak_new;
    logic [21:0]       mt_round;
    logic [dat_pkg::MARGIN_W-1:0] mt;
    logic [dat_pkg::TIME_W-1:0]   absent;
    dat_pkg::out_t     dec_out;

    assign seen_cur  = {seen1_reg[idx_reg], seen0_reg[idx_reg]};
    assign out_free  = !m_valid_reg || m_ready;
    assign out_push  = (cmd.emit_step && ev_flag_reg && pend_valid_reg)
                     || (cmd.flush_push && pend_valid_reg);

    assign stat.used_cur   = used_reg[idx_reg];
    assign stat.hit        = used_reg[idx_reg]
                           && rdata_reg.tag_high == in_reg.tag_id_high
                           && rdata_reg.tag_low == in_reg.tag_id_low;
    assign stat.idx_last   = (idx_reg == IDX_LAST);
    assign stat.free_avail = free_found_reg || !used_reg[idx_reg];
    assign stat.ev_flag    = ev_flag_reg;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // smoothing: new = old + round(alpha * (raw - old) / 256)
    assign alpha_sat = (alpha_reg > 9'd256) ? 9'd256 : alpha_reg;
    assign raw_a  = $signed({rec_reg.rssi[cmd.ant], 8'b0});
    assign old_a  = $signed(rec_reg.sm[cmd.ant]);
    assign diff_a = $signed({raw_a[19], raw_a}) - $signed({old_a[19], old_a});
    assign prod_c = $signed({1'b0, alpha_sat}) * diff_a;
    assign step_c = (prod_reg + 31'sd128) >>> 8;
    assign sum_c  = $signed({old_a[19], old_a}) + step_c[20:0];
    assign new_sm = sum_c[19:0];

    always_comb begin
        sm_rec              = rec_reg;
        sm_rec.smv[cmd.ant] = 1'b1;
        sm_rec.sm[cmd.ant]  = rec_reg.smv[cmd.ant] ? new_sm : raw_a;
    end

    always_comb begin
        push_data      = pend_reg;
        push_data.last = cmd.flush_push;
    end

    // read update record
    always_comb begin
        if (alloc_reg) begin
            wr_rec          = '0;
            wr_rec.tag_high = in_reg.tag_id_high;
            wr_rec.tag_low  = in_reg.tag_id_low;
            wr_rec.cand     = dat_pkg::ANT_NONE;
            wr_rec.owner    = dat_pkg::ANT_NONE;
            wr_rec.start_ms = in_reg.time_ms;
            rd_seen_a       = 1'b0;
        end else begin
            wr_rec    = rdata_reg;
            rd_seen_a = seen_cur[in_reg.antenna];
        end
        rd_take = !rd_seen_a
                || ($signed(in_reg.rssi_tenths) > $signed(wr_rec.rssi[in_reg.antenna]));
        if (rd_take) begin
            wr_rec.rssi[in_reg.antenna] = in_reg.rssi_tenths;
        end
        wr_rec.last_ms = in_reg.time_ms;
    end

    // per-slot decision
    always_comb begin
        dec_rec     = rec_reg;
        d0          = $signed(rec_reg.sm[0]);
        d1          = $signed(rec_reg.sm[1]);
        dd          = $signed({d0[19], d0}) - $signed({d1[19], d1});
        sole        = !(seen_cur[0] && seen_cur[1]);
        if (sole) begin
            cand   = !seen_cur[0];
            margin = '0;
        end else begin
            cand   = (d0 < d1);
            margin = dd[20] ? 21'(-dd) : 21'(dd);
        end
        lvl         = cand ? d1 : d0;
        pass        = (lvl >= $signed({floor_reg, 8'b0}))
                    && (sole || margin >= {3'b0, mmargin_reg, 8'b0});
        absent      = in_reg.time_ms - rec_reg.last_ms;
        release_now = (seen_cur == 2'b00) && (absent > {16'b0, rel_reg});
        if (rec_reg.cand == {1'b0, cand}) begin
            streak_new = (rec_reg.streak == 8'd255) ? 8'd255 : rec_reg.streak + 8'd1;
        end else begin
            streak_new = 8'd1;
        end
        commit   = (seen_cur != 2'b00) && (rec_reg.owner == dat_pkg::ANT_NONE)
                 && pass && (streak_new >= confirm_reg);
        mt_round = {1'b0, margin} + 22'd128;
        if (sole || mt_round[21:8] > {2'b0, dat_pkg::MARGIN_SAT}) begin
            mt = dat_pkg::MARGIN_SAT;
        end else begin
            mt = mt_round[19:8];
        end
        if ((seen_cur != 2'b00) && (rec_reg.owner == dat_pkg::ANT_NONE) && pass) begin
            dec_rec.cand   = {1'b0, cand};
            dec_rec.streak = streak_new;
            if (commit) begin
                dec_rec.owner = {1'b0, cand};
            end
        end
        dec_out      = '0;
        dec_out.slot = dat_pkg::SLOT_W'(idx_reg);
        dec_out.tag_high = rec_reg.tag_high;
        dec_out.tag_low  = rec_reg.tag_low;
        if (release_now) begin
            dec_out.event_res     = dat_pkg::EV_RELEASE;
            dec_out.owner_antenna = rec_reg.owner[0];
        end else begin
            dec_out.event_res     = dat_pkg::EV_COMMIT;
            dec_out.owner_antenna = cand;
            dec_out.margin_tenths = mt;
            dec_out.sole_reader   = sole;
            dec_out.decide_ms     = in_reg.time_ms - rec_reg.start_ms;
        end
        dec_ev = (release_now && rec_reg.owner != dat_pkg::ANT_NONE) || commit;
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.in_load) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end else if (cmd.goto_free && free_found_reg) begin
            idx_next = free_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rdata_reg <= mem[idx_reg];
        end
        if (cmd.read_wr) begin
            mem[idx_reg] <= wr_rec;
        end else if (cmd.dec_en) begin
            mem[idx_reg] <= dec_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_reg <= s_data;
        end
        if (cmd.cmp_step && !used_reg[idx_reg] && !free_found_reg) begin
            free_reg <= idx_reg;
        end
        if (cmd.rec_load) begin
            rec_reg <= rdata_reg;
        end else if (cmd.add_en && seen_cur[cmd.ant]) begin
            rec_reg <= sm_rec;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_c;
        end
        if (cmd.dec_en) begin
            ev_reg <= dec_out;
        end
        if (cmd.emit_step && ev_flag_reg) begin
            pend_reg <= ev_reg;
        end
        if (out_push) begin
            m_data_reg <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_reg        <= 16'd800;
            mmargin_reg    <= 10'd10;
            floor_reg      <= 12'hC7C;
            confirm_reg    <= 8'd5;
            alpha_reg      <= 9'd102;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            alloc_reg      <= 1'b0;
            used_reg       <= '0;
            seen0_reg      <= '0;
            seen1_reg      <= '0;
            ev_flag_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            n_reg          <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    dat_pkg::CFG_RELEASE: rel_reg     <= cfg_data;
                    dat_pkg::CFG_MARGIN:  mmargin_reg <= cfg_data[9:0];
                    dat_pkg::CFG_FLOOR:   floor_reg   <= cfg_data[11:0];
                    dat_pkg::CFG_CONFIRM: confirm_reg <= cfg_data[7:0];
                    dat_pkg::CFG_ALPHA:   alpha_reg   <= cfg_data[8:0];
                    default: ;
                endcase
            end
            idx_reg <= idx_next;
            if (cmd.in_load) begin
                free_found_reg <= 1'b0;
            end else if (cmd.cmp_step && !used_reg[idx_reg]) begin
                free_found_reg <= 1'b1;
            end
            if (cmd.set_hit) begin
                alloc_reg <= 1'b0;
            end else if (cmd.goto_free) begin
                alloc_reg <= 1'b1;
            end
            if (cmd.read_wr) begin
                used_reg[idx_reg] <= 1'b1;
                if (in_reg.antenna) begin
                    seen1_reg[idx_reg] <= 1'b1;
                    if (alloc_reg) seen0_reg[idx_reg] <= 1'b0;
                end else begin
                    seen0_reg[idx_reg] <= 1'b1;
                    if (alloc_reg) seen1_reg[idx_reg] <= 1'b0;
                end
            end else if (cmd.dec_en && release_now) begin
                used_reg[idx_reg] <= 1'b0;
            end else if (cmd.seen_clr) begin
                seen0_reg <= '0;
                seen1_reg <= '0;
            end
            if (cmd.sweep_init) begin
                n_reg <= '0;
            end else if (cmd.dec_en && dec_ev && n_reg < dat_pkg::MAX_EVENTS) begin
                n_reg <= n_reg + dat_pkg::EVN_W'(1);
            end
            if (cmd.dec_en) begin
                ev_flag_reg <= dec_ev && (n_reg < dat_pkg::MAX_EVENTS);
            end else if (cmd.emit_step) begin
                ev_flag_reg <= 1'b0;
            end
            if (cmd.sweep_init) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.emit_step && ev_flag_reg) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush_push) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_evn_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= dat_pkg::MAX_EVENTS)
        else $error("event count beyond limit");
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> out_free)
        else $error("output overwritten while stalled");
    a_seen_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seen_clr |=> (seen0_reg == '0 && seen1_reg == '0))
        else $error("seen flags not cleared at sweep end");
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush_push && pend_valid_reg) |=> (m_valid_reg && m_data_reg.last))
        else $error("final sweep event lacks last flag");
`endif

endmodule

[rtl/dual_antenna_tag_arbiter.sv]
// Top level of the dual-antenna tag arbiter: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_data  (dat_pkg::in_t)
//  m_      | out       | m_valid / m_ready    | m_data  (dat_pkg::out_t)
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A read item scans the slots, with one table memory read and one tag
// compare per slot scanned, then writes the slot record.
// A sweep-end item skips each free slot and takes each used slot through read,
// two multiply/add smoothing passes, decide and emit, then flushes; events wait
// for m_ready when the output register and the pending event are both full.
// Reset is synchronous on aresetn low; no clearing pass is needed.
module dual_antenna_tag_arbiter #(
    parameter int TRACK_COUNT = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dat_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output dat_pkg::out_t                  m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dat_pkg::CFG_DATA_W-1:0] cfg_data
);

    dat_pkg::cmd_t  cmd;
    dat_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    dat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dat_dpath #(
        .TRACK_COUNT (TRACK_COUNT)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[verif/tb_dual_antenna_tag_arbiter.sv]
// Testbench for the dual-antenna tag arbiter: directed table, then random sweeps checked by a predictor.
`timescale 1ns / 1ps

module tb_dual_antenna_tag_arbiter;

    localparam int SLOTS = 32;
    localparam int DRAIN_CYCLES = 300;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    dat_pkg::in_t s_data;
    logic m_valid;
    logic m_ready;
    dat_pkg::out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [dat_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dat_pkg::CFG_DATA_W-1:0] cfg_data;

    dual_antenna_tag_arbiter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of registers and track table
    int unsigned rel_ms;
    int unsigned min_margin;
    int floor_lvl;
    int unsigned confirm_n;
    int unsigned alpha_q8;

    bit used [SLOTS];
    logic [dat_pkg::TAG_HI_W-1:0] trk_hi [SLOTS];
    logic [dat_pkg::TAG_LO_W-1:0] trk_lo [SLOTS];
    bit seen [SLOTS][2];
    int peak_rssi [SLOTS][2];
    int smoothed [SLOTS][2];
    bit sm_valid [SLOTS][2];
    logic [1:0] cand [SLOTS];
    int streak [SLOTS];
    logic [1:0] owner [SLOTS];
    logic [31:0] first_t [SLOTS];
    logic [31:0] last_t [SLOTS];

    dat_pkg::out_t pending_events [$];
    int fails;
    bit calm;
    bit hold_req;
    logic [31:0] now_ms;

    logic [dat_pkg::TAG_HI_W-1:0] pool_hi [40];
    logic [dat_pkg::TAG_LO_W-1:0] pool_lo [40];
    int pool_lvl [40];
    bit pool_ant [40];

    typedef struct {
        logic op;
        logic ant;
        logic [31:0] hi;
        logic [63:0] lo;
        int rssi;
        logic [31:0] t;
        int exp_n;
        logic exp_ev;
        int exp_margin;
    } dir_row_t;

    localparam logic [31:0] A_HI = 32'hFFFF_FFFF;
    localparam logic [63:0] A_LO = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] B_HI = 32'h8000_0001;
    localparam logic [63:0] B_LO = 64'h0123_4567_89AB_CDEF;

    dir_row_t dir_rows [23];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int sx12(logic [11:0] v);
        return int'($signed(v));
    endfunction

    task automatic reset_track_table();
        rel_ms = 800;
        min_margin = 10;
        floor_lvl = -900;
        confirm_n = 5;
        alpha_q8 = 102;
        for (int s = 0; s < SLOTS; s++) begin
            used[s] = 1'b0;
        end
    endtask

    task automatic apply_cfg(logic [dat_pkg::CFG_IDX_W-1:0] idx,
                             logic [dat_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            dat_pkg::CFG_RELEASE: rel_ms = 32'(val);
            dat_pkg::CFG_MARGIN: min_margin = 32'(val[9:0]);
            dat_pkg::CFG_FLOOR: floor_lvl = sx12(val[11:0]);
            dat_pkg::CFG_CONFIRM: confirm_n = 32'(val[7:0]);
            dat_pkg::CFG_ALPHA: alpha_q8 = 32'(val[8:0]);
            default: ;
        endcase
    endtask

    task automatic track_read(dat_pkg::in_t it);
        int t;
        int rs;
        t = -1;
        rs = sx12(it.rssi_tenths);
        for (int s = 0; s < SLOTS && t < 0; s++) begin
            if (used[s] && trk_hi[s] == it.tag_id_high && trk_lo[s] == it.tag_id_low) t = s;
        end
        for (int s = 0; s < SLOTS && t < 0; s++) begin
            if (!used[s]) begin
                used[s] = 1'b1;
                trk_hi[s] = it.tag_id_high;
                trk_lo[s] = it.tag_id_low;
                for (int a = 0; a < 2; a++) begin
                    seen[s][a] = 1'b0;
                    peak_rssi[s][a] = 0;
                    smoothed[s][a] = 0;
                    sm_valid[s][a] = 1'b0;
                end
                cand[s] = dat_pkg::ANT_NONE;
                streak[s] = 0;
                owner[s] = dat_pkg::ANT_NONE;
                first_t[s] = it.time_ms;
                t = s;
            end
        end
        if (t >= 0) begin
            if (!seen[t][it.antenna] || rs > peak_rssi[t][it.antenna])
                peak_rssi[t][it.antenna] = rs;
            seen[t][it.antenna] = 1'b1;
            last_t[t] = it.time_ms;
        end
    endtask

    task automatic track_sweep(logic [31:0] now, output int n, output dat_pkg::out_t first_ev);
        dat_pkg::out_t evs [$];
        dat_pkg::out_t ev;
        longint al;
        longint p;
        bit sole;
        logic [1:0] c;
        int lvl;
        int mg;
        int unsigned mt;
        al = (alpha_q8 > 256) ? 256 : alpha_q8;
        for (int s = 0; s < SLOTS; s++) begin
            if (!used[s]) continue;
            ev = '0;
            ev.slot = s[dat_pkg::SLOT_W-1:0];
            ev.tag_high = trk_hi[s];
            ev.tag_low = trk_lo[s];
            if (!seen[s][0] && !seen[s][1]) begin
                if (now - last_t[s] > rel_ms) begin
                    if (owner[s] != dat_pkg::ANT_NONE) begin
                        ev.event_res = dat_pkg::EV_RELEASE;
                        ev.owner_antenna = owner[s][0];
                        if (evs.size() < SLOTS) evs.push_back(ev);
                    end
                    used[s] = 1'b0;
                end
                continue;
            end
            for (int a = 0; a < 2; a++) begin
                if (!seen[s][a]) continue;
                if (!sm_valid[s][a]) begin
                    smoothed[s][a] = peak_rssi[s][a] * 256;
                    sm_valid[s][a] = 1'b1;
                end else begin
                    p = al * (peak_rssi[s][a] * 256) + (256 - al) * smoothed[s][a] + 128;
                    smoothed[s][a] = int'(p >>> 8);
                end
            end
            if (owner[s] != dat_pkg::ANT_NONE) continue;
            sole = !(seen[s][0] && seen[s][1]);
            mg = 0;
            if (!sole) begin
                c = (smoothed[s][0] >= smoothed[s][1]) ? 2'd0 : 2'd1;
                mg = smoothed[s][c] - smoothed[s][1 - c];
            end else begin
                c = seen[s][0] ? 2'd0 : 2'd1;
            end
            lvl = smoothed[s][c];
            if (lvl < floor_lvl * 256) continue;
            if (!sole && mg < int'(min_margin) * 256) continue;
            if (cand[s] == c) begin
                if (streak[s] < 255) streak[s]++;
            end else begin
                cand[s] = c;
                streak[s] = 1;
            end
            if (streak[s] >= confirm_n) begin
                owner[s] = c;
                mt = sole ? 2559 : (mg + 128) >> 8;
                if (mt > 2559) mt = 2559;
                ev.event_res = dat_pkg::EV_COMMIT;
                ev.owner_antenna = c[0];
                ev.margin_tenths = mt[dat_pkg::MARGIN_W-1:0];
                ev.sole_reader = sole;
                ev.decide_ms = now - first_t[s];
                if (evs.size() < SLOTS) evs.push_back(ev);
            end
        end
        for (int s = 0; s < SLOTS; s++) begin
            seen[s][0] = 1'b0;
            seen[s][1] = 1'b0;
        end
        n = evs.size();
        first_ev = '0;
        if (n > 0) begin
            evs[n - 1].last = 1'b1;
            first_ev = evs[0];
        end
        foreach (evs[i]) pending_events.push_back(evs[i]);
    endtask

    task automatic send_item(dat_pkg::in_t it, output int n, output dat_pkg::out_t first_ev);
        if (!calm && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        n = 0;
        first_ev = '0;
        if (it.op == dat_pkg::OP_READ) track_read(it);
        else track_sweep(it.time_ms, n, first_ev);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [dat_pkg::CFG_IDX_W-1:0] idx,
                             logic [dat_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_cfg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int rel, int mg, int flr, int cnf, int alp);
        logic [11:0] f12;
        f12 = flr[11:0];
        wait_idle();
        write_cfg(dat_pkg::CFG_RELEASE, rel[15:0]);
        write_cfg(dat_pkg::CFG_MARGIN, mg[15:0]);
        write_cfg(dat_pkg::CFG_FLOOR, {4'b0, f12});
        write_cfg(dat_pkg::CFG_CONFIRM, cnf[15:0]);
        write_cfg(dat_pkg::CFG_ALPHA, alp[15:0]);
    endtask

    function automatic dat_pkg::in_t noise_fields();
        dat_pkg::in_t it;
        it.op = dat_pkg::OP_READ;
        it.antenna = $urandom_range(0, 1);
        it.tag_id_high = $urandom;
        it.tag_id_low = {$urandom, $urandom};
        it.rssi_tenths = $urandom_range(0, 4095);
        it.time_ms = now_ms;
        if (it.rssi_tenths[11:8] == 4'h7 || it.rssi_tenths[11:8] == 4'h8)
            it.rssi_tenths = 12'h000;
        return it;
    endfunction

    task automatic random_phase(int target, int pool_n);
        dat_pkg::in_t it;
        int sent;
        int k;
        int lvl;
        int n;
        dat_pkg::out_t fe;
        sent = 0;
        while (sent < target) begin
            repeat ($urandom_range(2, 10)) begin
                it = noise_fields();
                if ($urandom_range(0, 9) == 0) begin
                    // stray tag, often a new one
                end else begin
                    k = $urandom_range(0, pool_n - 1);
                    it.tag_id_high = pool_hi[k];
                    it.tag_id_low = pool_lo[k];
                    it.antenna = ($urandom_range(0, 4) == 0) ? !pool_ant[k] : pool_ant[k];
                    lvl = pool_lvl[k] + $urandom_range(0, 60) - 30;
                    if (it.antenna != pool_ant[k]) lvl -= $urandom_range(0, 200);
                    if (lvl < -1280) lvl = -1280;
                    if (lvl > 1279) lvl = 1279;
                    it.rssi_tenths = lvl[11:0];
                end
                send_item(it, n, fe);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) now_ms += $urandom_range(500, 70000);
            else now_ms += $urandom_range(50, 400);
            it = noise_fields();
            it.op = dat_pkg::OP_SWEEP;
            it.time_ms = now_ms;
            send_item(it, n, fe);
            sent++;
        end
    endtask

    always @(posedge aclk) begin
        dat_pkg::out_t ex;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $error("event with none expected: slot %0d", m_data.slot);
                fails++;
            end else begin
                ex = pending_events.pop_front();
                if (m_data.event_res !== ex.event_res) begin
                    $error("event_res expected %0h got %0h", ex.event_res, m_data.event_res);
                    fails++;
                end
                if (m_data.slot !== ex.slot) begin
                    $error("slot expected %0d got %0d", ex.slot, m_data.slot);
                    fails++;
                end
                if (m_data.owner_antenna !== ex.owner_antenna) begin
                    $error("owner_antenna expected %0h got %0h", ex.owner_antenna,
                           m_data.owner_antenna);
                    fails++;
                end
                if (m_data.tag_high !== ex.tag_high) begin
                    $error("tag_high expected %0h got %0h", ex.tag_high, m_data.tag_high);
                    fails++;
                end
                if (m_data.tag_low !== ex.tag_low) begin
                    $error("tag_low expected %0h got %0h", ex.tag_low, m_data.tag_low);
                    fails++;
                end
                if (m_data.margin_tenths !== ex.margin_tenths) begin
                    $error("margin_tenths expected %0d got %0d", ex.margin_tenths,
                           m_data.margin_tenths);
                    fails++;
                end
                if (m_data.sole_reader !== ex.sole_reader) begin
                    $error("sole_reader expected %0h got %0h", ex.sole_reader,
                           m_data.sole_reader);
                    fails++;
                end
                if (m_data.decide_ms !== ex.decide_ms) begin
                    $error("decide_ms expected %0d got %0d", ex.decide_ms, m_data.decide_ms);
                    fails++;
                end
                if (m_data.last !== ex.last) begin
                    $error("last expected %0h got %0h", ex.last, m_data.last);
                    fails++;
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        dat_pkg::in_t it;
        int n;
        dat_pkg::out_t fe;
        fails = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        now_ms = 0;
        reset_track_table();
        dir_rows = '{
            '{dat_pkg::OP_SWEEP, 0, 0, 0, 0, 0, 0, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, A_HI, A_LO, 1279, 10, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, 0, 0, -100, 10, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 1, 0, 0, -100, 10, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 1, B_HI, B_LO, -1280, 10, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_SWEEP, 1, A_HI, A_LO, 0, 20, 0, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, A_HI, A_LO, 1279, 30, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, 0, 0, -100, 30, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 1, 0, 0, -100, 30, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_SWEEP, 0, 0, 0, 0, 40, 0, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, A_HI, A_LO, 1279, 50, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, 0, 0, -100, 50, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 1, 0, 0, -100, 50, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_SWEEP, 0, 0, 0, 0, 60, 0, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, A_HI, A_LO, 1279, 70, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, 0, 0, -100, 70, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 1, 0, 0, -100, 70, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_SWEEP, 0, 0, 0, 0, 80, 0, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, A_HI, A_LO, 1279, 90, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 0, 0, 0, -100, 90, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_READ, 1, 0, 0, -100, 90, -1, dat_pkg::EV_COMMIT, 0},
            '{dat_pkg::OP_SWEEP, 0, 0, 0, 0, 100, 1, dat_pkg::EV_COMMIT, 2559},
            '{dat_pkg::OP_SWEEP, 1, B_HI, B_LO, 1279, 2000, 1, dat_pkg::EV_RELEASE, 0}
        };
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            it.op = dir_rows[i].op;
            it.antenna = dir_rows[i].ant;
            it.tag_id_high = dir_rows[i].hi;
            it.tag_id_low = dir_rows[i].lo;
            it.rssi_tenths = dir_rows[i].rssi[11:0];
            it.time_ms = dir_rows[i].t;
            send_item(it, n, fe);
            if (dir_rows[i].exp_n >= 0) begin
                if (n != dir_rows[i].exp_n) begin
                    $error("event count expected %0d got %0d", dir_rows[i].exp_n, n);
                    fails++;
                end
                if (n > 0 && (fe.event_res !== dir_rows[i].exp_ev ||
                              fe.margin_tenths != dir_rows[i].exp_margin)) begin
                    $error("directed event expected %0h/%0d got %0h/%0d",
                           dir_rows[i].exp_ev, dir_rows[i].exp_margin,
                           fe.event_res, fe.margin_tenths);
                    fails++;
                end
            end
        end
        now_ms = 2000;

        for (int k = 0; k < 40; k++) begin
            pool_hi[k] = $urandom;
            pool_lo[k] = {$urandom, $urandom};
            pool_lvl[k] = $urandom_range(0, 2559) - 1280;
            pool_ant[k] = $urandom_range(0, 1);
        end

        random_phase(80, 12);
        set_regs(0, 0, -1280, 1, 256);
        hold_req = 1'b1;
        random_phase(90, 40);
        set_regs(65535, 1000, 0, 255, 0);
        random_phase(70, 20);
        set_regs(300, 25, -600, 2, 128);
        now_ms = 32'hFFFF_F000;
        random_phase(90, 24);
        set_regs(100, 7, -1000, 3, 200);
        calm = 1'b1;
        random_phase(90, 16);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
